// ----- design/mdsa_pkg.sv -----
package mdsa_pkg;

  localparam int unsigned BANK_REGS = 8;
  localparam int unsigned MAX_UNITS = 255;
  localparam int unsigned MAX_DIMS  = 255;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned REC_W    = 2;
  localparam int unsigned KIND_W   = 4;
  localparam int unsigned SRC_W    = 2;
  localparam int unsigned OFS_W    = 11;
  localparam int unsigned ERR_W    = 2;
  localparam int unsigned BREG_W   = 4;
  localparam int unsigned UNITS_W  = 9;
  localparam int unsigned DEPTH_W  = 9;
  localparam int unsigned PRIM_W   = 3;
  localparam int unsigned NUM_PRIM = 8;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [REC_W-1:0] REC_SLOT = 2'd0;
  localparam logic [REC_W-1:0] REC_OK   = 2'd1;
  localparam logic [REC_W-1:0] REC_ERR  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_LONG   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_FLOAT  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_DOUBLE = 4'd7;
  localparam logic [KIND_W-1:0] KIND_REF    = 4'd8;
  localparam logic [KIND_W-1:0] KIND_VOID   = 4'd9;

  localparam logic [SRC_W-1:0] SRC_GP    = 2'd0;
  localparam logic [SRC_W-1:0] SRC_FP    = 2'd1;
  localparam logic [SRC_W-1:0] SRC_STACK = 2'd2;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OPEN  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_PARAM = 2'd2;
  localparam logic [ERR_W-1:0] ERR_RET   = 2'd3;

  localparam logic [BREG_W-1:0] GP_FIRST = 4'd2;
  localparam logic [OFS_W-1:0]  SLOT_BYTES = 11'd8;

  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3b;
  localparam logic [CHAR_W-1:0] CH_CLS   = 8'h4c;
  localparam logic [CHAR_W-1:0] CH_VOID  = 8'h56;
  localparam logic [CHAR_W-1:0] CH_ARR   = 8'h5b;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7f;

  // Primitive type letters in type_kind order: Z B C S I J F D.
  localparam logic [CHAR_W-1:0] PRIM_CHARS [NUM_PRIM] = '{
    8'h5a, 8'h42, 8'h43, 8'h53, 8'h49, 8'h4a, 8'h46, 8'h44
  };

  typedef enum logic [2:0] {
    PH_OPEN  = 3'd0,
    PH_PARAM = 3'd1,
    PH_PNAME = 3'd2,
    PH_PDIM  = 3'd3,
    PH_RET   = 3'd4,
    PH_RNAME = 3'd5,
    PH_RDIM  = 3'd6,
    PH_DONE  = 3'd7
  } phase_e;

  // One classified descriptor character.
  typedef struct packed {
    logic              last;
    logic              is_prim;
    logic [PRIM_W-1:0] prim_idx;
    logic              is_open;
    logic              is_close;
    logic              is_cls;
    logic              is_arr;
    logic              is_semi;
    logic              is_void;
    logic              name_bad;
  } tok_t;

endpackage

// ----- design/mdsa_in_if.sv -----
interface mdsa_in_if
  import mdsa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last_char;

  modport source (output valid, output character, output last_char, input ready);
  modport sink (input valid, input character, input last_char, output ready);
endinterface

// ----- design/mdsa_out_if.sv -----
interface mdsa_out_if
  import mdsa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [REC_W-1:0]  record_type;
  logic [KIND_W-1:0] type_kind;
  logic [SRC_W-1:0]  slot_source;
  logic [OFS_W-1:0]  slot_offset;
  logic [ERR_W-1:0]  error_code;
  logic              is_final;

  modport source (output valid, output record_type, output type_kind, output slot_source,
                  output slot_offset, output error_code, output is_final, input ready);
  modport sink (input valid, input record_type, input type_kind, input slot_source,
                input slot_offset, input error_code, input is_final, output ready);
endinterface

// ----- design/method_descriptor_slot_allocator_core.sv -----
// Method descriptor slot allocator. Descriptor characters enter one word per clock cycle
// while the queue has room, with no gaps needed between descriptors. A stateless
// classifier sorts each character and pushes it into a two-entry queue; the parser behind
// the queue takes one character per cycle while its output register is free or being
// read, assigns register-bank or stack slots, and writes at most one result word into an
// output register. A character is held in the queue, then its result is registered in the
// output register. No reset sweep is needed.
module method_descriptor_slot_allocator_core
  import mdsa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mdsa_in_if.sink    in_i,
  mdsa_out_if.source out_o
);

  logic cls_valid, cls_ready;
  tok_t cls_tok;
  logic q_valid, q_ready;
  tok_t q_tok;

  mdsa_classify u_classify (
    .in_i        (in_i),
    .tok_valid_o (cls_valid),
    .tok_o       (cls_tok),
    .tok_ready_i (cls_ready)
  );

  mdsa_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cls_valid),
    .push_ready_o (cls_ready),
    .push_data_i  (cls_tok),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_tok)
  );

  mdsa_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_i       (q_tok),
    .tok_ready_o (q_ready),
    .out_o       (out_o)
  );

endmodule

// ----- design/mdsa_classify.sv -----
module mdsa_classify
  import mdsa_pkg::*;
(
  mdsa_in_if.sink in_i,
  output logic    tok_valid_o,
  output tok_t    tok_o,
  input  logic    tok_ready_i
);

  logic [CHAR_W-1:0] c;

  assign c = in_i.character;

  always_comb begin
    tok_o          = '0;
    tok_o.last     = in_i.last_char;
    for (int i = 0; i < NUM_PRIM; i++) begin
      if (c == PRIM_CHARS[i]) begin
        tok_o.is_prim  = 1'b1;
        tok_o.prim_idx = PRIM_W'(i);
      end
    end
    tok_o.is_open  = (c == CH_OPEN);
    tok_o.is_close = (c == CH_CLOSE);
    tok_o.is_cls   = (c == CH_CLS);
    tok_o.is_arr   = (c == CH_ARR);
    tok_o.is_semi  = (c == CH_SEMI);
    tok_o.is_void  = (c == CH_VOID);
    tok_o.name_bad = (c <= CH_SPACE) || (c >= CH_DEL) || (c == CH_DOT) ||
                     (c == CH_ARR) || (c == CH_OPEN) || (c == CH_CLOSE);
  end

  assign tok_valid_o = in_i.valid;
  assign in_i.ready  = tok_ready_i;

endmodule

// ----- design/mdsa_fifo.sv -----
module mdsa_fifo
  import mdsa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  tok_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output tok_t pop_data_o
);

  tok_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count beyond its depth");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

// ----- design/mdsa_parse.sv -----
module mdsa_parse
  import mdsa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        tok_valid_i,
  input  tok_t        tok_i,
  output logic        tok_ready_o,
  mdsa_out_if.source  out_o
);

  phase_e             phase_q, phase_d;
  logic [BREG_W-1:0]  gp_q, gp_d;
  logic [BREG_W-1:0]  fp_q, fp_d;
  logic [UNITS_W-1:0] units_q, units_d;
  logic [OFS_W-1:0]   stack_q, stack_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic               nonempty_q, nonempty_d;
  logic [KIND_W-1:0]  ret_kind_q, ret_kind_d;
  logic [ERR_W-1:0]   err_q, err_d;

  logic               out_valid_q, out_valid_d;
  logic [REC_W-1:0]   rec_q, rec_d;
  logic [KIND_W-1:0]  kind_q, kind_d;
  logic [SRC_W-1:0]   src_q, src_d;
  logic [OFS_W-1:0]   ofs_q, ofs_d;
  logic [ERR_W-1:0]   code_q, code_d;
  logic               final_q, final_d;

  logic               pop, in_ret, place_req, place_fl, slot_ok;
  logic [KIND_W-1:0]  place_kind;
  logic [UNITS_W-1:0] units_sum;
  logic [BREG_W-1:0]  bank_reg;
  logic [DEPTH_W-1:0] depth_inc;
  logic [ERR_W-1:0]   fail_code, final_err;

  assign pop         = tok_valid_i && (!out_valid_q || out_o.ready);
  assign tok_ready_o = !out_valid_q || out_o.ready;
  assign in_ret      = (phase_q == PH_RET) || (phase_q == PH_RNAME) ||
                       (phase_q == PH_RDIM) || (phase_q == PH_DONE);
  assign fail_code   = in_ret ? ERR_RET : ERR_PARAM;
  assign depth_inc   = depth_q + 1'b1;

  always_comb begin
    phase_d     = phase_q;
    gp_d        = gp_q;
    fp_d        = fp_q;
    units_d     = units_q;
    stack_d     = stack_q;
    depth_d     = depth_q;
    nonempty_d  = nonempty_q;
    ret_kind_d  = ret_kind_q;
    err_d       = err_q;
    place_req   = 1'b0;
    place_kind  = KIND_REF;
    place_fl    = 1'b0;
    slot_ok     = 1'b0;
    units_sum   = units_q;
    bank_reg    = gp_q;
    final_err   = ERR_NONE;
    out_valid_d = out_valid_q && !out_o.ready;
    rec_d       = rec_q;
    kind_d      = kind_q;
    src_d       = src_q;
    ofs_d       = ofs_q;
    code_d      = code_q;
    final_d     = final_q;

    if (pop && (err_q == ERR_NONE)) begin
      unique case (phase_q)
        PH_OPEN: begin
          if (tok_i.is_open) begin
            phase_d = PH_PARAM;
          end else begin
            err_d = ERR_OPEN;
          end
        end
        PH_PARAM, PH_RET: begin
          if (!in_ret && tok_i.is_close) begin
            phase_d = PH_RET;
          end else if (tok_i.is_prim) begin
            if (!in_ret) begin
              place_req  = 1'b1;
              place_kind = KIND_W'(tok_i.prim_idx);
            end else begin
              ret_kind_d = KIND_W'(tok_i.prim_idx);
              phase_d    = PH_DONE;
            end
          end else if (in_ret && tok_i.is_void) begin
            ret_kind_d = KIND_VOID;
            phase_d    = PH_DONE;
          end else if (tok_i.is_cls) begin
            nonempty_d = 1'b0;
            phase_d    = in_ret ? PH_RNAME : PH_PNAME;
          end else if (tok_i.is_arr) begin
            depth_d = DEPTH_W'(1);
            if (DEPTH_W'(1) > DEPTH_W'(MAX_DIMS)) begin
              err_d = fail_code;
            end else begin
              phase_d = in_ret ? PH_RDIM : PH_PDIM;
            end
          end else begin
            err_d = fail_code;
          end
        end
        PH_PNAME, PH_RNAME: begin
          if (tok_i.is_semi) begin
            if (!nonempty_q) begin
              err_d = fail_code;
            end else begin
              nonempty_d = 1'b0;
              if (!in_ret) begin
                phase_d   = PH_PARAM;
                place_req = 1'b1;
              end else begin
                ret_kind_d = KIND_REF;
                phase_d    = PH_DONE;
              end
            end
          end else if (tok_i.name_bad) begin
            err_d = fail_code;
          end else begin
            nonempty_d = 1'b1;
          end
        end
        PH_PDIM, PH_RDIM: begin
          if (tok_i.is_arr) begin
            depth_d = depth_inc;
            if (depth_inc > DEPTH_W'(MAX_DIMS)) begin
              err_d = fail_code;
            end
          end else if (tok_i.is_prim) begin
            depth_d = '0;
            if (!in_ret) begin
              phase_d   = PH_PARAM;
              place_req = 1'b1;
            end else begin
              ret_kind_d = KIND_REF;
              phase_d    = PH_DONE;
            end
          end else if (tok_i.is_cls) begin
            depth_d    = '0;
            nonempty_d = 1'b0;
            phase_d    = in_ret ? PH_RNAME : PH_PNAME;
          end else begin
            err_d = fail_code;
          end
        end
        PH_DONE: begin
          err_d = ERR_RET;
        end
        default: begin
          err_d = ERR_RET;
        end
      endcase
    end

    // Slot assignment for a finished parameter; long and double take two units.
    if (place_req) begin
      place_fl  = (place_kind == KIND_FLOAT) || (place_kind == KIND_DOUBLE);
      units_sum = units_q + (((place_kind == KIND_LONG) || (place_kind == KIND_DOUBLE)) ?
                             UNITS_W'(2) : UNITS_W'(1));
      bank_reg  = place_fl ? fp_q : gp_q;
      if (units_sum > UNITS_W'(MAX_UNITS)) begin
        err_d = ERR_PARAM;
      end else begin
        slot_ok = 1'b1;
        units_d = units_sum;
        kind_d  = place_kind;
        rec_d   = REC_SLOT;
        code_d  = ERR_NONE;
        final_d = 1'b0;
        if (bank_reg < BREG_W'(BANK_REGS)) begin
          src_d = place_fl ? SRC_FP : SRC_GP;
          ofs_d = OFS_W'(bank_reg) << 3;
          if (place_fl) begin
            fp_d = bank_reg + 1'b1;
          end else begin
            gp_d = bank_reg + 1'b1;
          end
        end else begin
          src_d   = SRC_STACK;
          ofs_d   = stack_q;
          stack_d = stack_q + SLOT_BYTES;
        end
      end
    end

    if (pop && tok_i.last) begin
      final_err = err_d;
      if ((err_d == ERR_NONE) && (phase_d != PH_DONE)) begin
        priority if (phase_d == PH_OPEN) begin
          final_err = ERR_OPEN;
        end else if ((phase_d == PH_PNAME) || (phase_d == PH_PDIM)) begin
          final_err = ERR_PARAM;
        end else begin
          final_err = ERR_RET;
        end
      end
      out_valid_d = 1'b1;
      src_d       = SRC_GP;
      ofs_d       = '0;
      final_d     = 1'b1;
      if (final_err != ERR_NONE) begin
        rec_d  = REC_ERR;
        kind_d = '0;
        code_d = final_err;
      end else begin
        rec_d  = REC_OK;
        kind_d = ret_kind_d;
        code_d = ERR_NONE;
      end
      // The next word starts a fresh descriptor.
      phase_d    = PH_OPEN;
      gp_d       = GP_FIRST;
      fp_d       = '0;
      units_d    = '0;
      stack_d    = '0;
      depth_d    = '0;
      nonempty_d = 1'b0;
      ret_kind_d = '0;
      err_d      = ERR_NONE;
    end else if (slot_ok) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OPEN;
      gp_q        <= GP_FIRST;
      fp_q        <= '0;
      units_q     <= '0;
      stack_q     <= '0;
      depth_q     <= '0;
      nonempty_q  <= 1'b0;
      ret_kind_q  <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      gp_q        <= gp_d;
      fp_q        <= fp_d;
      units_q     <= units_d;
      stack_q     <= stack_d;
      depth_q     <= depth_d;
      nonempty_q  <= nonempty_d;
      ret_kind_q  <= ret_kind_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q   <= rec_d;
    kind_q  <= kind_d;
    src_q   <= src_d;
    ofs_q   <= ofs_d;
    code_q  <= code_d;
    final_q <= final_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.record_type = rec_q;
  assign out_o.type_kind   = kind_q;
  assign out_o.slot_source = src_q;
  assign out_o.slot_offset = ofs_q;
  assign out_o.error_code  = code_q;
  assign out_o.is_final    = final_q;

  a_units_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    units_q <= UNITS_W'(MAX_UNITS))
    else $error("parameter units beyond limit");

  a_fresh_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && tok_i.last) |=> (phase_q == PH_OPEN && err_q == ERR_NONE &&
                             units_q == '0 && gp_q == GP_FIRST))
    else $error("parser state not restored after last character");

  a_slot_not_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && rec_q == REC_SLOT) |-> (!final_q && code_q == ERR_NONE))
    else $error("slot record marked as final or with an error");

  a_no_slot_after_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ERR_NONE && pop) |=> !(out_valid_q && rec_q == REC_SLOT))
    else $error("slot record emitted after an error");

endmodule

// ----- tb/slot_record_checker.sv -----
`timescale 1ns / 1ps

module slot_record_checker
  import mdsa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [CHAR_W-1:0] character_i,
  input  logic              last_char_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [REC_W-1:0]  record_type_i,
  input  logic [KIND_W-1:0] type_kind_i,
  input  logic [SRC_W-1:0]  slot_source_i,
  input  logic [OFS_W-1:0]  slot_offset_i,
  input  logic [ERR_W-1:0]  error_code_i,
  input  logic              is_final_i,
  output int                mismatch_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [REC_W-1:0]  rec;
    logic [KIND_W-1:0] kind;
    logic [SRC_W-1:0]  src;
    logic [OFS_W-1:0]  ofs;
    logic [ERR_W-1:0]  err;
    logic              fin;
  } slot_rec_t;

  // Parser state of the prediction.
  phase_e             phase;
  logic [BREG_W-1:0]  gp_used;
  logic [BREG_W-1:0]  fp_used;
  logic [UNITS_W-1:0] units;
  logic [OFS_W-1:0]   stack_ofs;
  logic [DEPTH_W-1:0] depth;
  logic               name_seen;
  logic [KIND_W-1:0]  ret_kind;
  logic [ERR_W-1:0]   err_code;

  slot_rec_t expected_recs[$];
  int        mismatches;

  function automatic void clear_parser();
    phase     = PH_OPEN;
    gp_used   = GP_FIRST;
    fp_used   = '0;
    units     = '0;
    stack_ofs = '0;
    depth     = '0;
    name_seen = 1'b0;
    ret_kind  = '0;
    err_code  = ERR_NONE;
  endfunction

  function automatic bit prim_lookup(input logic [CHAR_W-1:0] ch,
                                     output logic [PRIM_W-1:0] idx);
    int k;
    idx = '0;
    for (k = 0; k < NUM_PRIM; k++) begin
      if (PRIM_CHARS[k] == ch) begin
        idx = PRIM_W'(k);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit bad_name_char(input logic [CHAR_W-1:0] ch);
    return ch <= CH_SPACE || ch >= CH_DEL || ch == CH_DOT || ch == CH_ARR ||
           ch == CH_OPEN || ch == CH_CLOSE;
  endfunction

  // Assigns a bank register or a stack slot to one finished parameter.
  function automatic bit place_param(input logic [KIND_W-1:0] kind, output slot_rec_t rec);
    logic              is_fp;
    int unsigned       width;
    logic [BREG_W-1:0] reg_idx;
    rec   = '0;
    is_fp = (kind == KIND_FLOAT) || (kind == KIND_DOUBLE);
    width = (kind == KIND_LONG || kind == KIND_DOUBLE) ? 2 : 1;
    if (int'(units) + width > MAX_UNITS) begin
      err_code = ERR_PARAM;
      return 1'b0;
    end
    units    = units + UNITS_W'(width);
    rec.rec  = REC_SLOT;
    rec.kind = kind;
    reg_idx  = is_fp ? fp_used : gp_used;
    if (reg_idx < BANK_REGS) begin
      rec.src = is_fp ? SRC_FP : SRC_GP;
      rec.ofs = reg_idx * SLOT_BYTES;
      if (is_fp) fp_used = reg_idx + 1'b1;
      else gp_used = reg_idx + 1'b1;
    end else begin
      rec.src   = SRC_STACK;
      rec.ofs   = stack_ofs;
      stack_ofs = stack_ofs + SLOT_BYTES;
    end
    return 1'b1;
  endfunction

  function automatic bit advance_char(input logic [CHAR_W-1:0] ch, output slot_rec_t rec);
    logic              is_prim;
    logic [PRIM_W-1:0] pidx;
    logic              in_ret;
    logic [ERR_W-1:0]  code;
    bit                made;
    rec     = '0;
    made    = 1'b0;
    is_prim = prim_lookup(ch, pidx);
    in_ret  = phase >= PH_RET;
    code    = in_ret ? ERR_RET : ERR_PARAM;
    case (phase)
      PH_OPEN: begin
        if (ch == CH_OPEN) phase = PH_PARAM;
        else err_code = ERR_OPEN;
      end
      PH_PARAM, PH_RET: begin
        if (!in_ret && ch == CH_CLOSE) begin
          phase = PH_RET;
        end else if (is_prim) begin
          if (!in_ret) begin
            made = place_param(KIND_W'(pidx), rec);
          end else begin
            ret_kind = KIND_W'(pidx);
            phase    = PH_DONE;
          end
        end else if (in_ret && ch == CH_VOID) begin
          ret_kind = KIND_VOID;
          phase    = PH_DONE;
        end else if (ch == CH_CLS) begin
          name_seen = 1'b0;
          phase     = in_ret ? PH_RNAME : PH_PNAME;
        end else if (ch == CH_ARR) begin
          depth = DEPTH_W'(1);
          phase = in_ret ? PH_RDIM : PH_PDIM;
        end else begin
          err_code = code;
        end
      end
      PH_PNAME, PH_RNAME: begin
        if (ch == CH_SEMI) begin
          if (!name_seen) begin
            err_code = code;
          end else begin
            name_seen = 1'b0;
            if (!in_ret) begin
              phase = PH_PARAM;
              made  = place_param(KIND_REF, rec);
            end else begin
              ret_kind = KIND_REF;
              phase    = PH_DONE;
            end
          end
        end else if (bad_name_char(ch)) begin
          err_code = code;
        end else begin
          name_seen = 1'b1;
        end
      end
      PH_PDIM, PH_RDIM: begin
        if (ch == CH_ARR) begin
          depth = depth + 1'b1;
          if (depth > MAX_DIMS) err_code = code;
        end else if (is_prim) begin
          depth = '0;
          if (!in_ret) begin
            phase = PH_PARAM;
            made  = place_param(KIND_REF, rec);
          end else begin
            ret_kind = KIND_REF;
            phase    = PH_DONE;
          end
        end else if (ch == CH_CLS) begin
          depth     = '0;
          name_seen = 1'b0;
          phase     = in_ret ? PH_RNAME : PH_PNAME;
        end else begin
          err_code = code;
        end
      end
      default: err_code = ERR_RET;
    endcase
    return made;
  endfunction

  // Returns 1 when the word produces a record. On the final word a slot that
  // would complete is dropped, but its unit count still applies.
  function automatic bit predict_word(input logic [CHAR_W-1:0] ch, input logic last,
                                      output slot_rec_t rec);
    slot_rec_t slot;
    bit        made;
    rec  = '0;
    slot = '0;
    made = 1'b0;
    if (err_code == ERR_NONE) made = advance_char(ch, slot);
    if (!last) begin
      rec = slot;
      return made && err_code == ERR_NONE;
    end
    if (err_code == ERR_NONE && phase != PH_DONE) begin
      if (phase == PH_OPEN) err_code = ERR_OPEN;
      else if (phase == PH_PNAME || phase == PH_PDIM) err_code = ERR_PARAM;
      else err_code = ERR_RET;
    end
    rec.fin = 1'b1;
    if (err_code != ERR_NONE) begin
      rec.rec = REC_ERR;
      rec.err = err_code;
    end else begin
      rec.rec  = REC_OK;
      rec.kind = ret_kind;
    end
    clear_parser();
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : monitor
    slot_rec_t rec;
    slot_rec_t want;
    slot_rec_t got;
    if (!rst_ni) begin
      clear_parser();
      expected_recs.delete();
      mismatches = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (predict_word(character_i, last_char_i, rec)) begin
          expected_recs.insert(expected_recs.size(), rec);
        end
      end
      if (out_valid_i && out_ready_i) begin
        got = '{record_type_i, type_kind_i, slot_source_i, slot_offset_i, error_code_i,
                is_final_i};
        if (expected_recs.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected word: rec=%0d kind=%0d src=%0d ofs=%0d err=%0d fin=%0d",
                     got.rec, got.kind, got.src, got.ofs, got.err, got.fin);
          end
          mismatches++;
        end else begin
          want = expected_recs.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("mismatch: expected rec=%0d kind=%0d src=%0d ofs=%0d err=%0d fin=%0d",
                       want.rec, want.kind, want.src, want.ofs, want.err, want.fin);
              $display("          actual   rec=%0d kind=%0d src=%0d ofs=%0d err=%0d fin=%0d",
                       got.rec, got.kind, got.src, got.ofs, got.err, got.fin);
            end
            mismatches++;
          end
        end
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= expected_recs.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench
  import mdsa_pkg::*;
();

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mdsa_in_if  in_if ();
  mdsa_out_if out_if ();

  int mismatch_total;
  int records_pending;

  method_descriptor_slot_allocator_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  slot_record_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_if.valid),
    .in_ready_i       (in_if.ready),
    .character_i      (in_if.character),
    .last_char_i      (in_if.last_char),
    .out_valid_i      (out_if.valid),
    .out_ready_i      (out_if.ready),
    .record_type_i    (out_if.record_type),
    .type_kind_i      (out_if.type_kind),
    .slot_source_i    (out_if.slot_source),
    .slot_offset_i    (out_if.slot_offset),
    .error_code_i     (out_if.error_code),
    .is_final_i       (out_if.is_final),
    .mismatch_count_o (mismatch_total),
    .pending_o        (records_pending)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random stall modes, with a long periodic hold-off so
  // that the block backs up while the sender keeps offering words.
  initial begin : receiver
    int mode;
    int mode_left;
    int cycle_no;
    int hold_left;
    mode      = 0;
    mode_left = 0;
    cycle_no  = 0;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      cycle_no++;
      if (cycle_no % 1500 == 300) hold_left = $urandom_range(40, 80);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (mode == 0) begin
        out_if.ready <= 1'b1;
      end else if (mode == 1) begin
        out_if.ready <= 1'($urandom_range(0, 1));
      end else begin
        out_if.ready <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  logic [CHAR_W-1:0] desc_bytes[$];
  int                burst_left;
  int                random_words;

  function automatic void append_byte(input logic [CHAR_W-1:0] ch);
    desc_bytes.insert(desc_bytes.size(), ch);
  endfunction

  task automatic send_word(input logic [CHAR_W-1:0] ch, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_if.valid     <= 1'b1;
    in_if.character <= ch;
    in_if.last_char <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic send_desc();
    int i;
    for (i = 0; i < desc_bytes.size(); i++) begin
      send_word(desc_bytes[i], i == desc_bytes.size() - 1);
    end
    desc_bytes.delete();
  endtask

  function automatic void add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  function automatic void add_rep(input logic [CHAR_W-1:0] ch, input int n);
    repeat (n) append_byte(ch);
  endfunction

  task automatic send_text(input string s);
    add_text(s);
    send_desc();
  endtask

  function automatic void add_class_name();
    logic [CHAR_W-1:0] ch;
    append_byte(CH_CLS);
    repeat ($urandom_range(1, 6)) begin
      do begin
        ch = CHAR_W'($urandom_range(8'h21, 8'h7e));
      end while (ch == CH_DOT || ch == CH_ARR || ch == CH_OPEN || ch == CH_CLOSE ||
                 ch == CH_SEMI);
      append_byte(ch);
    end
    append_byte(CH_SEMI);
  endfunction

  function automatic void add_type(input bit in_return);
    int pick;
    pick = $urandom_range(0, 9);
    if (in_return && pick == 9) begin
      append_byte(CH_VOID);
    end else if (pick < 6) begin
      append_byte(PRIM_CHARS[$urandom_range(0, NUM_PRIM - 1)]);
    end else if (pick < 8) begin
      add_class_name();
    end else begin
      add_rep(CH_ARR, $urandom_range(1, 3));
      if ($urandom_range(0, 1) == 0) append_byte(PRIM_CHARS[$urandom_range(0, 7)]);
      else add_class_name();
    end
  endfunction

  // Mostly well-formed descriptors; the rest are noise, a corrupted byte,
  // an early end or trailing data.
  task automatic send_random_desc();
    int flavor;
    int keep;
    flavor = $urandom_range(0, 9);
    if (flavor == 0) begin
      repeat ($urandom_range(1, 5)) append_byte(CHAR_W'($urandom_range(0, 255)));
    end else begin
      append_byte(CH_OPEN);
      repeat (($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6)) begin
        add_type(1'b0);
      end
      append_byte(CH_CLOSE);
      add_type(1'b1);
      if (flavor == 1) begin
        desc_bytes[$urandom_range(0, desc_bytes.size() - 1)] = CHAR_W'($urandom_range(0, 255));
      end else if (flavor == 2) begin
        keep = $urandom_range(1, desc_bytes.size() - 1);
        while (desc_bytes.size() > keep) void'(desc_bytes.pop_back());
      end else if (flavor == 3) begin
        append_byte(CHAR_W'($urandom_range(0, 255)));
      end
    end
    random_words += desc_bytes.size();
    send_desc();
  endtask

  initial begin : stimulus
    burst_left       = 0;
    random_words     = 0;
    in_if.valid      = 1'b0;
    in_if.character  = '0;
    in_if.last_char  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("()V");
    send_text("(ZBCSIJFD)I");
    // Both banks overflow onto the shared stack.
    send_text("(JJJJJJJFFFFFFFFFD)D");
    send_text("(Ljava/lang/String;[[I[Lx;)[Lq;");
    send_text("X");
    send_text("(");
    send_text("(I");
    send_text("(L;)V");
    send_text("(La.b;)V");
    send_text("(La b;)V");
    send_text("([V)V");
    send_text("()VI");
    send_text("()X");
    send_text("()[V");
    send_text("(Lab");
    send_text("([");
    send_text("()L");
    send_text("Q(I)V");
    // Unit limit: the list fills exactly to the limit, then one more overflows.
    add_text("(");
    add_rep("J", 127);
    add_text("II)V");
    send_desc();
    // One array dimension past the limit inside the parameter list.
    add_text("(");
    add_rep(CH_ARR, MAX_DIMS + 1);
    add_text("I)V");
    send_desc();

    while (random_words < 60) send_random_desc();

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (records_pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_total == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
